// ----- src/hfs_pkg.sv -----
// Shared types, constants and the sine table for the Hilbert frequency shifter.
// No dependencies; every other file but hfs_checker imports this package.
package hfs_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int HIST_BITS   = SAMPLE_BITS + 2;
	localparam int TAB_DEPTH   = 1025;

	localparam logic [2:0] REG_ENABLE  = 3'd0;
	localparam logic [2:0] REG_STEREO  = 3'd1;
	localparam logic [2:0] REG_STEP    = 3'd2;
	localparam logic [2:0] REG_MIX     = 3'd3;
	localparam logic [2:0] REG_OFFSET  = 3'd4;
	localparam logic [2:0] REG_I_COEF  = 3'd5;
	localparam logic [2:0] REG_Q_COEF  = 3'd6;

	localparam logic [4:0] CNT_SIN  = 5'd1;
	localparam logic [4:0] CNT_COS  = 5'd3;
	localparam logic [4:0] CNT_P1   = 5'd16;
	localparam logic [4:0] CNT_P2   = 5'd17;
	localparam logic [4:0] CNT_WM   = 5'd18;
	localparam logic [4:0] CNT_DM   = 5'd19;
	localparam logic [4:0] CNT_LAST = 5'd20;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       run;
		logic [4:0] cnt;
		logic       clear;
	} lane_ctrl_t;

	typedef logic [14:0] sin_tab_t [0:TAB_DEPTH-1];

	function automatic sin_tab_t build_sin_tab();
		sin_tab_t    t;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] r;
		for (int k = 0; k < TAB_DEPTH; k++) begin
			x  = 64'(k) << 20;
			x2 = (x * x) >> 30;
			p  = 64'd172272;
			p  = 64'd5026995 - ((x2 * p) >> 30);
			p  = 64'd85569306 - ((x2 * p) >> 30);
			p  = 64'd693598668 - ((x2 * p) >> 30);
			p  = 64'd1686629713 - ((x2 * p) >> 30);
			r  = (x * p) >> 30;
			r  = (r + 64'd16384) >> 15;
			t[k] = (r > 64'd32767) ? 15'h7fff : r[14:0];
		end
		return t;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

// ----- src/hfs_sine.sv -----
// Quarter-wave sine lookup with quadrant folding, one registered read per cycle.
// Depends on hfs_pkg for the table.
module hfs_sine import hfs_pkg::*; (
	input  logic               clk,
	input  logic [31:0]        phase,
	output logic signed [15:0] value
);

	logic [9:0]  frac;
	logic [10:0] k;
	logic [14:0] tab_q;
	logic        neg_q;

	always_comb begin
		frac = phase[29:20];
		k    = phase[30] ? (11'd1024 - {1'b0, frac}) : {1'b0, frac};
	end

	always_ff @(posedge clk) begin
		tab_q <= SIN_TAB[k];
		neg_q <= phase[31];
	end

	assign value = neg_q ? -$signed({1'b0, tab_q}) : $signed({1'b0, tab_q});

endmodule

// ----- src/hfs_lane.sv -----
// One channel lane: I and Q allpass cascades on a shared multiplier, sine/cosine
// lookup, I/Q mixing and dry/wet blend. Depends on hfs_pkg and hfs_sine.
module hfs_lane import hfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctrl_t         ctrl,
	input  logic signed [15:0] dry,
	input  logic [31:0]        phase,
	input  logic [63:0]        i_coef,
	input  logic [63:0]        q_coef,
	input  logic [16:0]        mix,
	output logic signed [15:0] result
);

	logic [2:0]         s;
	logic               chain_on;
	logic signed [17:0] in_hist_q [8];
	logic signed [17:0] out_hist_q [8];
	logic signed [17:0] x_q;
	logic signed [17:0] i_q;
	logic signed [17:0] q_q;
	logic signed [17:0] x_eff;
	logic [15:0]        coef;
	logic signed [18:0] diff;
	logic signed [35:0] prod_s1;
	logic signed [19:0] prod_rnd;
	logic signed [20:0] y_sum;
	logic signed [17:0] y;
	logic [31:0]        sine_phase;
	logic signed [15:0] sine_val;
	logic signed [15:0] si_q;
	logic signed [15:0] co_q;
	logic signed [33:0] p1_s1;
	logic signed [33:0] p2_s1;
	logic signed [34:0] wet;
	logic signed [51:0] wm_prod;
	logic signed [52:0] wm_q;
	logic [16:0]        n;
	logic signed [32:0] dm_prod;
	logic signed [32:0] dm_q;
	logic signed [53:0] acc;
	logic signed [22:0] acc_rnd;
	logic signed [15:0] result_q;

	assign s        = ctrl.cnt[3:1];
	assign chain_on = ctrl.run && !ctrl.cnt[4];

	always_comb begin
		x_eff = (s[1:0] == 2'd0) ? 18'(dry) : x_q;
		coef  = s[2] ? q_coef[{s[1:0], 4'b0} +: 16] : i_coef[{s[1:0], 4'b0} +: 16];
		diff  = 19'(x_eff) - 19'(out_hist_q[s]);
		prod_rnd = 20'((prod_s1 + 36'sd32768) >>> 16);
		y_sum = 21'(prod_rnd) + 21'(in_hist_q[s]);
		if (y_sum > 21'sd131071)
			y = 18'sd131071;
		else if (y_sum < -21'sd131072)
			y = -18'sd131072;
		else
			y = y_sum[17:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < 8; e++) begin
				in_hist_q[e]  <= '0;
				out_hist_q[e] <= '0;
			end
		end else if (ctrl.clear) begin
			for (int e = 0; e < 8; e++) begin
				in_hist_q[e]  <= '0;
				out_hist_q[e] <= '0;
			end
		end else if (chain_on && ctrl.cnt[0]) begin
			in_hist_q[s]  <= x_eff;
			out_hist_q[s] <= y;
		end
	end

	always_ff @(posedge clk) begin
		if (chain_on && !ctrl.cnt[0])
			prod_s1 <= $signed({1'b0, coef}) * diff;
		if (chain_on && ctrl.cnt[0]) begin
			x_q <= y;
			if (s == 3'd3)
				i_q <= y;
			if (s == 3'd7)
				q_q <= y;
		end
	end

	assign sine_phase = ctrl.cnt[1] ? (phase + 32'h4000_0000) : phase;

	hfs_sine u_sine (
		.clk   (clk),
		.phase (sine_phase),
		.value (sine_val)
	);

	always_comb begin
		wet     = 35'(p1_s1) - 35'(p2_s1);
		wm_prod = wet * $signed({1'b0, mix[15:0]});
		n       = 17'd65536 - mix;
		dm_prod = dry * $signed({1'b0, n[15:0]});
		acc     = (54'(dm_q) <<< 15) + 54'(wm_q);
		acc_rnd = 23'((acc + 54'sd1073741824) >>> 31);
	end

	always_ff @(posedge clk) begin
		if (ctrl.run) begin
			if (ctrl.cnt == CNT_SIN)
				si_q <= sine_val;
			if (ctrl.cnt == CNT_COS)
				co_q <= sine_val;
			if (ctrl.cnt == CNT_P1)
				p1_s1 <= i_q * co_q;
			if (ctrl.cnt == CNT_P2)
				p2_s1 <= q_q * si_q;
			if (ctrl.cnt == CNT_WM)
				wm_q <= mix[16] ? (53'(wet) <<< 16) : 53'(wm_prod);
			if (ctrl.cnt == CNT_DM)
				dm_q <= n[16] ? (33'(dry) <<< 16) : dm_prod;
			if (ctrl.cnt == CNT_LAST) begin
				if (acc_rnd > 23'sd32767)
					result_q <= 16'sd32767;
				else if (acc_rnd < -23'sd32768)
					result_q <= -16'sd32768;
				else
					result_q <= acc_rnd[15:0];
			end
		end
	end

	assign result = result_q;

endmodule

// ----- src/hilbert_frequency_shifter_core.sv -----
// Hilbert allpass frequency shifter, top level: configuration registers, phase
// accumulator, sequencer, two channel lanes and the merging output register.
// Depends on hfs_pkg and hfs_lane.
//
// Usage: one stereo frame is an item on the input channel (in_valid/in_ready,
// left_sample, right_sample); one blended frame leaves on the output channel
// (out_valid/out_ready, left_out, right_out). Registers are written through
// cfg_we/cfg_index/cfg_data while no item is in flight.
// With enable set the sequencer steps the eight allpass sections of each lane
// through one shared multiplier, then the mixing steps (cosine and sine
// products, wet mix, dry mix, rounding), before the result moves to the
// output register; both lanes run side by side in stereo mode. With enable
// clear an item bypasses the lanes and goes straight to the output register.
// A new item is accepted in the cycle after the result moves to the output
// register, so no new item is taken before the last one is through, and an
// item held in the output register does not block the next item.
// Reset clears the configuration registers, sequencer, output valid, filter history and phase, with stereo mode set.
// When the receiver stalls, the output register holds its item and a finished
// result waits in the lanes until the output register frees up.
module hilbert_frequency_shifter_core import hfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] left_sample,
	input  logic signed [15:0] right_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out
);

	logic               enable_q;
	logic               stereo_q;
	logic [31:0]        step_q;
	logic [16:0]        mix_q;
	logic [30:0]        offset_q;
	logic [63:0]        i_coef_q;
	logic [63:0]        q_coef_q;
	logic [31:0]        phase_q;
	state_t             state_q;
	state_t             state_d;
	logic [4:0]         cnt_q;
	logic signed [15:0] left_q;
	logic signed [15:0] right_q;
	logic               out_valid_q;
	logic signed [15:0] left_out_q;
	logic signed [15:0] right_out_q;
	logic               clear;
	logic               accept;
	logic               load_out;
	logic               busy_last;
	logic [16:0]        mix_lim;
	logic [30:0]        offset_lim;
	logic [31:0]        phase_right;
	lane_ctrl_t         ctrl_left;
	lane_ctrl_t         ctrl_right;
	logic signed [15:0] left_res;
	logic signed [15:0] right_res;

	assign clear = cfg_we && (cfg_index == REG_ENABLE) && !cfg_data[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			stereo_q <= 1'b1;
			step_q   <= '0;
			mix_q    <= '0;
			offset_q <= '0;
			i_coef_q <= '0;
			q_coef_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_STEREO: stereo_q <= cfg_data[0];
				REG_STEP:   step_q   <= cfg_data[31:0];
				REG_MIX:    mix_q    <= cfg_data[16:0];
				REG_OFFSET: offset_q <= cfg_data[30:0];
				REG_I_COEF: i_coef_q <= cfg_data;
				REG_Q_COEF: q_coef_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_comb begin
		mix_lim     = (mix_q > 17'd65536) ? 17'd65536 : mix_q;
		offset_lim  = (offset_q > 31'h4000_0000) ? 31'h4000_0000 : offset_q;
		phase_right = phase_q + {1'b0, offset_lim};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = enable_q ? ST_BUSY : ST_OUT;
			ST_BUSY: if (cnt_q == CNT_LAST) state_d = ST_OUT;
			ST_OUT:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		accept    = in_ready && in_valid;
		busy_last = (state_q == ST_BUSY) && (cnt_q == CNT_LAST);
		load_out  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_BUSY)
				cnt_q <= cnt_q + 5'd1;
			else
				cnt_q <= '0;
			if (clear)
				phase_q <= '0;
			else if (busy_last)
				phase_q <= phase_q + step_q;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_q  <= left_sample;
			right_q <= right_sample;
		end
		if (load_out) begin
			left_out_q <= enable_q ? left_res : left_q;
			if (!enable_q)
				right_out_q <= right_q;
			else if (stereo_q)
				right_out_q <= right_res;
			else
				right_out_q <= '0;
		end
	end

	always_comb begin
		ctrl_left.run    = (state_q == ST_BUSY);
		ctrl_left.cnt    = cnt_q;
		ctrl_left.clear  = clear;
		ctrl_right.run   = (state_q == ST_BUSY) && stereo_q;
		ctrl_right.cnt   = cnt_q;
		ctrl_right.clear = clear;
	end

	hfs_lane u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl_left),
		.dry    (left_q),
		.phase  (phase_q),
		.i_coef (i_coef_q),
		.q_coef (q_coef_q),
		.mix    (mix_lim),
		.result (left_res)
	);

	hfs_lane u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl_right),
		.dry    (right_q),
		.phase  (phase_right),
		.i_coef (i_coef_q),
		.q_coef (q_coef_q),
		.mix    (mix_lim),
		.result (right_res)
	);

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

endmodule

// ----- src/hfs_checker.sv -----
// Port-level checks for the frequency shifter core, bound to the top level.
// Depends only on the ports of hilbert_frequency_shifter_core.
module hfs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] left_out,
	input logic signed [15:0] right_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
		else $error("output item changed while stalled");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while one is in work");

endmodule

bind hilbert_frequency_shifter_core hfs_checker u_hfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.left_out  (left_out),
	.right_out (right_out)
);

// ----- tb/hilbert_frequency_shifter_core_tb.sv -----
// Testbench for hilbert_frequency_shifter_core: directed and random stereo frames under
// random handshake gaps, checked against a bit-exact frequency shifter predictor.
// Depends on hfs_pkg and the RTL top level only.
module hilbert_frequency_shifter_core_tb;
	import hfs_pkg::*;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
	} frame_t;

	class shift_scoreboard;
		bit        en;
		bit        stereo;
		bit [31:0] step;
		bit [16:0] mix;
		bit [30:0] offs;
		bit [63:0] icoef;
		bit [63:0] qcoef;
		longint    xin[16];
		longint    yout[16];
		bit [31:0] phase;
		frame_t    want[$];
		int        errors;
		int        checked;

		function new();
			en = 0; stereo = 1; step = 0; mix = 0; offs = 0; icoef = 0; qcoef = 0;
			errors = 0; checked = 0;
			clear();
		endfunction

		function void clear();
			for (int k = 0; k < 16; k++) begin
				xin[k] = 0;
				yout[k] = 0;
			end
			phase = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] val);
			case (idx)
				REG_ENABLE: begin
					en = val[0];
					if (!en) clear();
				end
				REG_STEREO: stereo = val[0];
				REG_STEP:   step = val[31:0];
				REG_MIX:    mix = val[16:0];
				REG_OFFSET: offs = val[30:0];
				REG_I_COEF: icoef = val;
				REG_Q_COEF: qcoef = val;
				default: ;
			endcase
		endfunction

		function longint clip(longint v, int bits);
			longint hi;
			hi = (longint'(1) <<< (bits - 1)) - 1;
			return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
		endfunction

		function longint round_shift(longint v, int n);
			return (v + (longint'(1) <<< (n - 1))) >>> n;
		endfunction

		function longint quarter_wave(int k);
			bit [63:0] x;
			bit [63:0] x2;
			bit [63:0] p;
			bit [63:0] r;
			x  = 64'(k) << 20;
			x2 = (x * x) >> 30;
			p  = 64'd172272;
			p  = 64'd5026995 - ((x2 * p) >> 30);
			p  = 64'd85569306 - ((x2 * p) >> 30);
			p  = 64'd693598668 - ((x2 * p) >> 30);
			p  = 64'd1686629713 - ((x2 * p) >> 30);
			r  = (x * p) >> 30;
			r  = (r + 64'd16384) >> 15;
			return r > 64'd32767 ? 32767 : longint'(r);
		endfunction

		function longint sine(bit [31:0] ph);
			bit [1:0] quad;
			int       k;
			longint   s;
			quad = ph[31:30];
			k = int'(ph[29:20]);
			if (quad[0]) k = 1024 - k;
			s = quarter_wave(k);
			return quad[1] ? -s : s;
		endfunction

		function longint allpass_chain(longint x, bit [63:0] coefs, int base);
			longint c;
			longint y;
			for (int s = 0; s < 4; s++) begin
				c = longint'(coefs[16*s +: 16]);
				y = round_shift(c * (x - yout[base+s]), 16) + xin[base+s];
				y = clip(y, HIST_BITS);
				xin[base+s] = x;
				yout[base+s] = y;
				x = y;
			end
			return x;
		endfunction

		function longint shift_channel(longint dry, int ch, bit [31:0] ph, longint m);
			longint i;
			longint q;
			longint wet;
			longint acc;
			i = allpass_chain(dry, icoef, ch * 8);
			q = allpass_chain(dry, qcoef, ch * 8 + 4);
			wet = i * sine(ph + 32'h4000_0000) - q * sine(ph);
			acc = dry * (65536 - m) * 32768 + wet * m;
			return clip(round_shift(acc, 31), SAMPLE_BITS);
		endfunction

		function void note_frame(logic signed [15:0] l, logic signed [15:0] r);
			frame_t    f;
			longint    m;
			bit [31:0] o;
			if (!en) begin
				clear();
				f.left = l;
				f.right = r;
			end else begin
				m = mix > 17'd65536 ? 65536 : longint'(mix);
				o = offs > 31'h4000_0000 ? 32'h4000_0000 : 32'(offs);
				f.left = 16'(shift_channel(longint'(l), 0, phase, m));
				f.right = stereo ? 16'(shift_channel(longint'(r), 1, phase + o, m)) : 16'sd0;
				phase += step;
			end
			want.push_back(f);
		endfunction

		function void check_frame(logic signed [15:0] l, logic signed [15:0] r);
			frame_t f;
			if (want.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected frame out: %0d %0d", l, r);
				return;
			end
			f = want.pop_front();
			checked++;
			if (l !== f.left || r !== f.right) begin
				errors++;
				if (errors <= 10)
					$display("frame %0d mismatch: expected %0d %0d, got %0d %0d",
						checked, f.left, f.right, l, r);
			end
		endfunction

		function int pending();
			return want.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [63:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;

	shift_scoreboard sb;
	bit quiet;
	bit hold_req;
	int sent;

	hilbert_frequency_shifter_core dut (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function bit gap();
		return !quiet && $urandom_range(99) < 34;
	endfunction

	task write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task send(logic signed [15:0] l, logic signed [15:0] r);
		@(negedge clk);
		if (gap()) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		do @(posedge clk); while (!in_ready);
		sb.note_frame(l, r);
		sent++;
	endtask

	task drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task send_random(int n);
		for (int k = 0; k < n; k++) send(16'($urandom), 16'($urandom));
	endtask

	function logic [63:0] pick_coefs();
		case ($urandom_range(5))
			0: return 64'h0;
			1: return 64'hffff_ffff_ffff_ffff;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	always begin
		@(posedge clk);
		if (arst_n && out_valid && out_ready) sb.check_frame(left_out, right_out);
		@(negedge clk);
		if (hold_req) begin
			out_ready <= 1'b0;
			repeat (300) @(negedge clk);
			hold_req = 1'b0;
		end
		out_ready <= !gap();
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [16:0] mix_pick;
		sb = new();
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		left_sample = '0;
		right_sample = '0;
		out_ready = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// pass-through while disabled
		send(16'sh7fff, -16'sh8000);
		send(-16'sh8000, 16'sh7fff);
		send(16'sd0, -16'sd1);
		drain();

		write_reg(REG_I_COEF, 64'hffff_8000_4000_0001);
		write_reg(REG_Q_COEF, 64'h0001_c000_ffff_2000);
		write_reg(REG_STEP, 64'h1000_0000);
		write_reg(REG_MIX, 64'd65536);
		write_reg(REG_OFFSET, 64'h4000_0000);
		write_reg(REG_ENABLE, 64'd1);
		send(16'sh7fff, 16'sh7fff);
		send(-16'sh8000, -16'sh8000);
		send(16'sh7fff, -16'sh8000);
		send(16'sd0, 16'sd0);
		send(-16'sd1, 16'sd1);
		drain();

		// over-range mix and offset, negative step
		write_reg(REG_MIX, 64'h1ffff);
		write_reg(REG_OFFSET, 64'h7fff_ffff);
		write_reg(REG_STEP, 64'h8000_0000);
		write_reg(3'd7, 64'hffff_ffff_ffff_ffff);
		send(16'sh7fff, -16'sh8000);
		send(-16'sh8000, 16'sh7fff);
		send(16'sh1234, -16'sh4321);
		drain();

		// mono, then zero mix
		write_reg(REG_STEREO, 64'd0);
		send(16'sh7fff, 16'sh7fff);
		send(-16'sh8000, 16'sh1111);
		drain();
		write_reg(REG_MIX, 64'd0);
		send(16'sh5555, -16'sh2aaa);
		drain();
		write_reg(REG_STEREO, 64'd1);
		write_reg(REG_ENABLE, 64'd0);
		write_reg(REG_ENABLE, 64'd1);
		send(16'sh4000, -16'sh4000);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			case ($urandom_range(3))
				0: mix_pick = 17'd0;
				1: mix_pick = 17'd65536;
				2: mix_pick = 17'h1ffff;
				default: mix_pick = 17'($urandom_range(65536));
			endcase
			write_reg(REG_ENABLE, 64'(ph != 3 && ph != 7 ? 1 : $urandom_range(1)));
			write_reg(REG_STEREO, 64'(ph % 4 != 2));
			write_reg(REG_STEP, 64'($urandom));
			write_reg(REG_MIX, 64'(mix_pick));
			write_reg(REG_OFFSET, 64'($urandom) & 64'h7fff_ffff);
			write_reg(REG_I_COEF, pick_coefs());
			write_reg(REG_Q_COEF, pick_coefs());
			quiet = (ph == 2);
			if (ph == 5) hold_req = 1'b1;
			send_random(145);
			drain();
		end
		quiet = 1'b0;

		repeat (30) @(posedge clk);
		$display("%0d frames sent, %0d checked over directed and nine random setups",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
